// ===== rtl/core/fh64_pkg.sv =====
`default_nettype none

package fh64_pkg;

  localparam logic [63:0] FH_MULT = 64'h880355f21e6d1965;
  localparam logic [63:0] FH_MIXK = 64'h2127599bf4325c37;
  localparam int unsigned MIX_SHIFT_A = 23;
  localparam int unsigned MIX_SHIFT_B = 47;

  // Request to the shared multiplier: start is a one-cycle pulse, a and b
  // are held until the next start.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } fh64_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } fh64_mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/fast_hash64_engine_top.sv =====
`default_nettype none

// Streaming fasthash64 engine. A message enters as little-endian 64-bit
// words, one item per word; total_len is taken from the first word of each
// message and last_word closes it and produces one hash_value item. Every
// 64-bit multiply runs on one shared 32x32 multiplier over three steps. A middle
// word takes two multiplies from acceptance to the next acceptance, a first word
// with a nonzero length also takes the length multiply first, and a last word
// adds the final avalanche multiply and then loads the output register. The
// finished hash waits in the output register while the next message is already
// being taken in. hash_seed is sampled when the first word of a message is
// processed.
module fast_hash64_engine_top
  import fh64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] data_word,
  input  wire logic [31:0] total_len,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    IDLE,
    INIT_WAIT,
    MIX_WAIT,
    HASH_WAIT,
    FIN_WAIT,
    EMIT
  } state_t;

  state_t        state;
  logic [63:0]   hash_seed;
  logic [63:0]   running_hash;
  logic          in_message;
  logic [2:0]    tail_bytes;
  logic [63:0]   word_r;
  logic          last_r;
  logic          mix_r;
  logic [63:0]   result;
  fh64_mul_req_t mul_req;
  fh64_mul_rsp_t mul_rsp;

  logic [2:0]    tail_sel;
  logic [2:0]    tail_inv;
  logic [63:0]   word_masked;
  logic [63:0]   init_hash;
  logic [63:0]   mixed_word;

  function automatic logic [63:0] xs23(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT_A);
  endfunction

  function automatic logic [63:0] xs47(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT_B);
  endfunction

  fh64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // On a last word with a partial tail, only the low tail bytes survive.
  always_comb begin
    tail_sel    = in_message ? tail_bytes : total_len[2:0];
    tail_inv    = 3'd0 - tail_sel;
    word_masked = data_word;
    if (last_word && (tail_sel != 3'd0)) begin
      word_masked = data_word & ({64{1'b1}} >> {tail_inv, 3'b000});
    end
    init_hash  = mul_rsp.prod ^ hash_seed;
    mixed_word = xs47(mul_rsp.prod);
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 64'd0;
    end else if (cfg_wr_en) begin
      hash_seed <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      running_hash  <= 64'd0;
      in_message    <= 1'b0;
      tail_bytes    <= 3'd0;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      if ((state == EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          mul_req.start <= in_valid;
          if (in_valid) begin
            word_r <= word_masked;
            last_r <= last_word;
            mix_r  <= in_message || (total_len != 32'd0);
            if (!in_message) begin
              tail_bytes <= total_len[2:0];
              mul_req.a  <= {32'd0, total_len};
              mul_req.b  <= FH_MULT;
              state      <= INIT_WAIT;
            end else begin
              mul_req.a <= xs23(word_masked);
              mul_req.b <= FH_MIXK;
              state     <= MIX_WAIT;
            end
          end
        end
        INIT_WAIT: begin
          mul_req.start <= mul_rsp.done && (mix_r || last_r);
          if (mul_rsp.done) begin
            if (mix_r) begin
              in_message   <= 1'b1;
              running_hash <= init_hash;
              mul_req.a    <= xs23(word_r);
              mul_req.b    <= FH_MIXK;
              state        <= MIX_WAIT;
            end else if (last_r) begin
              // A zero-length message goes straight to the avalanche.
              mul_req.a    <= xs23(init_hash);
              mul_req.b    <= FH_MIXK;
              in_message   <= 1'b0;
              tail_bytes   <= 3'd0;
              running_hash <= 64'd0;
              state        <= FIN_WAIT;
            end else begin
              in_message   <= 1'b1;
              running_hash <= init_hash;
              state        <= IDLE;
            end
          end
        end
        MIX_WAIT: begin
          mul_req.start <= mul_rsp.done;
          if (mul_rsp.done) begin
            mul_req.a <= running_hash ^ mixed_word;
            mul_req.b <= FH_MULT;
            state     <= HASH_WAIT;
          end
        end
        HASH_WAIT: begin
          mul_req.start <= mul_rsp.done && last_r;
          if (mul_rsp.done) begin
            if (last_r) begin
              mul_req.a    <= xs23(mul_rsp.prod);
              mul_req.b    <= FH_MIXK;
              in_message   <= 1'b0;
              tail_bytes   <= 3'd0;
              running_hash <= 64'd0;
              state        <= FIN_WAIT;
            end else begin
              running_hash <= mul_rsp.prod;
              state        <= IDLE;
            end
          end
        end
        FIN_WAIT: begin
          mul_req.start <= 1'b0;
          if (mul_rsp.done) begin
            result <= mixed_word;
            state  <= EMIT;
          end
        end
        EMIT: begin
          mul_req.start <= 1'b0;
          if (!out_valid || out_ready) begin
            hash_value <= result;
            state      <= IDLE;
          end
        end
        default: begin
          mul_req.start <= 1'b0;
          state         <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fh64_mul.sv =====
`default_nettype none

module fh64_mul
  import fh64_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fh64_mul_req_t req,
  output fh64_mul_rsp_t      rsp
);

  localparam logic [1:0] LastStep = 2'd2;

  logic [1:0]  step;
  logic        busy;
  logic [63:0] acc;
  logic        done;

  logic [1:0]  sel;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;
  logic [63:0] partial;

  // Low 64 bits of a 64x64 product from three 32x32 products: the low
  // cross terms land at bit 32, the high-by-high term falls off the top.
  always_comb begin
    sel     = req.start ? 2'd0 : step;
    op_x    = (sel == LastStep) ? req.a[63:32] : req.a[31:0];
    op_y    = (sel == 2'd1) ? req.b[63:32] : req.b[31:0];
    prod    = {32'b0, op_x} * {32'b0, op_y};
    partial = (sel == 2'd0) ? prod : {prod[31:0], 32'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (step == LastStep);
      if (req.start) begin
        acc  <= partial;
        step <= 2'd1;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc + partial;
        step <= step + 2'd1;
        if (step == LastStep) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fh64_pkg::*;

  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 350;

  typedef struct packed {
    logic [63:0] word;
    logic [31:0] len;
    logic        last;
    logic        typed;
    logic [63:0] hash;
  } dir_row_t;

  // Typed hashes are the zero-length messages under a zero seed, which finish as zero.
  localparam dir_row_t DIRECTED_ROWS [17] = '{
    '{64'h0000000000000000, 32'd0,          1'b1, 1'b1, 64'h0},
    '{64'hffffffffffffffff, 32'd8,          1'b1, 1'b0, 64'h0},
    '{64'hffffffffffffffff, 32'd1,          1'b1, 1'b0, 64'h0},
    '{64'hffffffffffffffff, 32'd7,          1'b1, 1'b0, 64'h0},
    '{64'h0000000000000000, 32'd0,          1'b0, 1'b0, 64'h0},
    '{64'h0123456789abcdef, 32'd99,         1'b0, 1'b0, 64'h0},
    '{64'hffffffffffffffff, 32'd0,          1'b1, 1'b0, 64'h0},
    '{64'h0000000000000000, 32'hffffffff,   1'b0, 1'b0, 64'h0},
    '{64'hffffffffffffffff, 32'd0,          1'b0, 1'b0, 64'h0},
    '{64'haaaaaaaaaaaaaaaa, 32'd5,          1'b1, 1'b0, 64'h0},
    '{64'h5555555555555555, 32'd16,         1'b0, 1'b0, 64'h0},
    '{64'hfedcba9876543210, 32'd3,          1'b0, 1'b0, 64'h0},
    '{64'h00000000ffffffff, 32'hffffffff,   1'b0, 1'b0, 64'h0},
    '{64'hffffffff00000000, 32'd0,          1'b1, 1'b0, 64'h0},
    '{64'h8000000000000000, 32'd9,          1'b1, 1'b0, 64'h0},
    '{64'h00000000000000ff, 32'd1,          1'b1, 1'b0, 64'h0},
    '{64'hffffffffffffffff, 32'd0,          1'b1, 1'b1, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] data_word = '0;
  logic [31:0] total_len = '0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] hash_value;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  fast_hash64_engine_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .total_len   (total_len),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the engine state.
  logic [63:0] seed_shadow = '0;
  logic [63:0] hash_acc = '0;
  bit          msg_open = 1'b0;
  logic [2:0]  tail_cnt = '0;

  logic [63:0] expected_hashes [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_max_gap = 19;
  int unsigned receiver_max_gap = 19;
  bit          hold_request = 1'b0;

  function automatic logic [63:0] avalanche(input logic [63:0] x);
    x = x ^ (x >> MIX_SHIFT_A);
    x = x * FH_MIXK;
    x = x ^ (x >> MIX_SHIFT_B);
    return x;
  endfunction

  // Folds one word into the shadow hash; returns 1 when the word closes a message.
  function automatic bit absorb_word(input logic [63:0] w, input logic [31:0] len,
                                     input bit last, output logic [63:0] digest);
    logic [63:0] v;
    bit          mix_it;
    mix_it = 1'b1;
    if (!msg_open) begin
      hash_acc = ({32'd0, len} * FH_MULT) ^ seed_shadow;
      tail_cnt = len[2:0];
      if (len == 32'd0) mix_it = 1'b0;
      msg_open = 1'b1;
    end
    if (mix_it) begin
      v = w;
      if (last && tail_cnt != 3'd0) v = v & ((64'd1 << (8 * tail_cnt)) - 64'd1);
      hash_acc = (hash_acc ^ avalanche(v)) * FH_MULT;
    end
    digest = avalanche(hash_acc);
    if (last) begin
      msg_open = 1'b0;
      tail_cnt = '0;
      hash_acc = '0;
    end
    return last;
  endfunction

  // Entered and left at a falling edge.
  task automatic drive_item(input logic [63:0] w, input logic [31:0] len, input bit last,
                            input bit typed, input logic [63:0] typed_hash);
    int unsigned gap;
    logic [63:0] digest;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_word <= w;
    total_len <= len;
    last_word <= last;
    if (absorb_word(w, len, last, digest)) begin
      expected_hashes.push_back(typed ? typed_hash : digest);
    end
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    seed_shadow = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [63:0] random_word;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed messages, with broken word counts and huge lengths mixed in.
  task automatic send_message;
    int unsigned pick;
    int unsigned nwords;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = $urandom_range(0, 40);
      nwords = (len == 0) ? 1 : (len + 7) / 8;
    end else if (pick < 80) begin
      len = $urandom_range(41, 200);
      nwords = (len + 7) / 8;
    end else if (pick < 90) begin
      len = $urandom_range(0, 40);
      nwords = $urandom_range(1, 6);
    end else begin
      len = $urandom;
      nwords = $urandom_range(1, 4);
    end
    for (int unsigned i = 0; i < nwords; i++) begin
      drive_item(random_word(), (i == 0) ? len : $urandom, i == nwords - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [63:0] seed, input int unsigned s_gap,
                           input int unsigned r_gap, input bit hold, input int unsigned n);
    int unsigned start;
    write_seed(seed);
    sender_max_gap   = s_gap;
    receiver_max_gap = r_gap;
    hold_request     = hold;
    start = items_sent;
    while (items_sent - start < n) send_message();
    drain();
  endtask

  initial begin
    logic [63:0] got;
    logic [63:0] want;
    int unsigned gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, receiver_max_gap);
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = hash_value;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash_value item, expected none, actual %016h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (got !== want) begin
          $display("%0t: hash_value mismatch, expected %016h, actual %016h",
                   $time, want, got);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fast_hash64_engine_top verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_seed(64'd0);
    foreach (DIRECTED_ROWS[i]) begin
      drive_item(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].last,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].hash);
    end
    drain();

    run_phase(64'hffffffffffffffff, 19, 19, 1'b0, PHASE_ITEMS);
    run_phase(64'd1, 0, 0, 1'b0, PHASE_ITEMS);
    // The sender keeps offering while the receiver holds off, so the engine backs up.
    run_phase({$urandom, $urandom}, 0, 19, 1'b1, PHASE_ITEMS);
    run_phase(64'h8000000000000000, 19, 0, 1'b0, PHASE_ITEMS);
    run_phase({$urandom, $urandom}, 19, 19, 1'b0, PHASE_ITEMS);

    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("fast_hash64_engine_top verification clean");
    end else begin
      $display("fast_hash64_engine_top verification failed");
    end
    $finish;
  end

endmodule
